// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL files
// Concurrent assertion wrappers; they compile to nothing when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define BPFA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define BPFA_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define BPFA_ASSERT(lbl, clk, rstn, prop, msg)
`define BPFA_ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

// File: rtl/bpfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfa_pkg
// Shared types and constants of the bitmap page frame allocator.
// ----------------------------------------------------------------------------
package bpfa_pkg;

  // default map geometry
  localparam int DEF_NUM_PAGES  = 16384;
  localparam int DEF_PAGE_SHIFT = 12;
  localparam int DEF_WORD_BITS  = 32;

  // port widths
  localparam int OPCODE_W    = 2;
  localparam int PAGE_ADDR_W = 32;
  localparam int GRANT_W     = 26;
  localparam int STATUS_W    = 2;
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;

  // config register widths and reset values
  localparam int RES_LOW_W   = 15;
  localparam int TBL_START_W = 14;
  localparam int TBL_COUNT_W = 15;
  localparam int CFG_SUM_W   = 16;  // table start + table count

  localparam logic [RES_LOW_W-1:0]   RES_LOW_RST   = RES_LOW_W'(256);
  localparam logic [TBL_START_W-1:0] TBL_START_RST = TBL_START_W'(256);
  localparam logic [TBL_COUNT_W-1:0] TBL_COUNT_RST = TBL_COUNT_W'(1);

  typedef enum logic [OPCODE_W-1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2
  } bpfa_op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_NO_MEM = 2'd1,
    ST_BEYOND = 2'd2
  } bpfa_status_e;

  // register index = paddr[3:2]
  typedef enum logic [1:0] {
    REG_RES_LOW   = 2'd0,
    REG_TBL_START = 2'd1,
    REG_TBL_COUNT = 2'd2
  } bpfa_reg_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_INIT,
    S_SCAN,
    S_SEEK,
    S_FWRITE,
    S_DONE
  } bpfa_state_e;

endpackage

// File: rtl/bitmap_page_frame_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator
// First-fit physical page allocator over a used/free bitmap held in RAM.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------
//  in      | input     | in_valid_i / in_stall_o    | opcode_i, page_address_i
//  out     | output    | out_valid_o / out_stall_i  | granted_address_o, status_o
//  cfg     | input     | APB psel/penable/pready    | paddr, pwdata, prdata
//
//  Each beat walks the map RAM one word per cycle
//  (MAP_WORDS = NUM_PAGES / WORD_BITS, rounded up; 512 by default):
//    init  : writes every word, alloc: reads words up to the first free page,
//    free  : seeks, reads, rewrites its word; beyond the map or unused opcode: none.
//  After reset a clearing pass writes zero to every map word; in_stall_o
//  stays high meanwhile, config writes are taken as ever.
//  One beat is in work at a time. The next beat is taken as soon as a result
//  sits in the output register, so a stalled output only blocks the next
//  result, not the next input.
//
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator #(
  parameter int NUM_PAGES  = bpfa_pkg::DEF_NUM_PAGES,
  parameter int PAGE_SHIFT = bpfa_pkg::DEF_PAGE_SHIFT,
  parameter int WORD_BITS  = bpfa_pkg::DEF_WORD_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // item input
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [bpfa_pkg::OPCODE_W-1:0]     opcode_i,
  input  logic [bpfa_pkg::PAGE_ADDR_W-1:0]  page_address_i,
  // result output
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [bpfa_pkg::GRANT_W-1:0]      granted_address_o,
  output logic [bpfa_pkg::STATUS_W-1:0]     status_o,
  // config port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bpfa_pkg::PADDR_W-1:0]      paddr,
  input  logic [bpfa_pkg::PDATA_W-1:0]      pwdata,
  output logic [bpfa_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);

  import bpfa_pkg::*;

  `include "assert_macros.svh"

  // --------------------------------------------------------------------------
  // Geometry
  // --------------------------------------------------------------------------
  localparam int MAP_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BIT_W     = $clog2(WORD_BITS);
  // page numbers, word bases and range ends all share CMPW, the wider of this and CFG_SUM_W
  localparam int BASE_W    = $clog2(NUM_PAGES + WORD_BITS);
  localparam int CMPW      = (BASE_W > CFG_SUM_W) ? BASE_W : CFG_SUM_W;
  localparam int PGX_W     = PAGE_ADDR_W + 1;

  localparam logic [AW-1:0]    LAST_WA   = AW'(MAP_WORDS - 1);
  localparam logic [CMPW-1:0]  WB_C      = CMPW'(WORD_BITS);
  localparam logic [CMPW-1:0]  NUM_C     = CMPW'(NUM_PAGES);
  localparam logic [PGX_W-1:0] NUM_X     = PGX_W'(NUM_PAGES);

  // --------------------------------------------------------------------------
  // Word mask helpers: bits whose page b+j is >= lo, or < hi
  // --------------------------------------------------------------------------
  function automatic logic [WORD_BITS-1:0] ge_mask(input logic [CMPW-1:0] b,
                                                   input logic [CMPW-1:0] lo);
    logic [CMPW-1:0] d;
    d = lo - b;
    if (lo <= b) begin
      ge_mask = {WORD_BITS{1'b1}};
    end else if (d >= WB_C) begin
      ge_mask = '0;
    end else begin
      ge_mask = {WORD_BITS{1'b1}} << d;
    end
  endfunction

  function automatic logic [WORD_BITS-1:0] lt_mask(input logic [CMPW-1:0] b,
                                                   input logic [CMPW-1:0] hi);
    logic [CMPW-1:0] d;
    d = hi - b;
    if (hi <= b) begin
      lt_mask = '0;
    end else if (d >= WB_C) begin
      lt_mask = {WORD_BITS{1'b1}};
    end else begin
      lt_mask = ~({WORD_BITS{1'b1}} << d);
    end
  endfunction

  // lowest set bit
  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = BIT_W'(i);
      end
    end
    lowest_set = idx;
  endfunction

  // --------------------------------------------------------------------------
  // Config registers
  // --------------------------------------------------------------------------
  logic [RES_LOW_W-1:0]   res_low_q;
  logic [TBL_START_W-1:0] tbl_start_q;
  logic [TBL_COUNT_W-1:0] tbl_count_q;
  logic                   cfg_we;
  bpfa_reg_e              cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = bpfa_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_low_q   <= RES_LOW_RST;
      tbl_start_q <= TBL_START_RST;
      tbl_count_q <= TBL_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_RES_LOW:   res_low_q   <= pwdata[RES_LOW_W-1:0];
        REG_TBL_START: tbl_start_q <= pwdata[TBL_START_W-1:0];
        REG_TBL_COUNT: tbl_count_q <= pwdata[TBL_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_RES_LOW:   prdata = PDATA_W'(res_low_q);
      REG_TBL_START: prdata = PDATA_W'(tbl_start_q);
      REG_TBL_COUNT: prdata = PDATA_W'(tbl_count_q);
      default:       prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Map RAM
  // --------------------------------------------------------------------------
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  bpfa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Sequencer state
  // --------------------------------------------------------------------------
  bpfa_state_e          state_q, state_d;
  logic [AW-1:0]        wa_q, wa_d;           // word walk pointer
  logic [CMPW-1:0]      base_q, base_d;       // first page of word wa_q
  logic                 scan_more_q, scan_more_d;
  logic                 rd_pend_q, rd_pend_d; // read data valid this cycle
  logic [AW-1:0]        rd_addr_q, rd_addr_d;
  logic [CMPW-1:0]      rd_base_q, rd_base_d;
  logic [CMPW-1:0]      tgt_q, tgt_d;         // page to free
  logic [BIT_W-1:0]     bit_q, bit_d;
  logic [GRANT_W-1:0]   res_grant_q, res_grant_d;
  bpfa_status_e         res_status_q, res_status_d;

  logic                 out_valid_q;
  logic [GRANT_W-1:0]   out_grant_q;
  bpfa_status_e         out_status_q;
  logic                 out_load;

  logic                 in_accept;
  logic [PGX_W-1:0]     free_pg;
  logic [CMPW-1:0]      tbl_end;
  logic [WORD_BITS-1:0] init_word;
  logic [WORD_BITS-1:0] free_bits;
  logic [BIT_W-1:0]     free_idx;
  logic [CMPW-1:0]      grant_pg;
  logic [CMPW+PAGE_SHIFT-1:0] grant_full;
  logic [CMPW-1:0]      seek_off;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign free_pg   = {1'b0, page_address_i} >> PAGE_SHIFT;
  assign tbl_end   = CMPW'(tbl_start_q) + CMPW'(tbl_count_q);
  // low reserved pages, plus the pages of the map itself
  assign init_word = lt_mask(base_q, CMPW'(res_low_q))
                   | (ge_mask(base_q, CMPW'(tbl_start_q)) & lt_mask(base_q, tbl_end));

  // free pages of the word just read; pad bits past the map count as used
  assign free_bits  = ~ram_rdata & lt_mask(rd_base_q, NUM_C);
  assign free_idx   = lowest_set(free_bits);
  assign grant_pg   = rd_base_q + CMPW'(free_idx);
  assign grant_full = {grant_pg, {PAGE_SHIFT{1'b0}}};

  assign seek_off   = tgt_q - base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      wa_q        <= '0;
      scan_more_q <= 1'b0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wa_q        <= wa_d;
      scan_more_q <= scan_more_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= (out_valid_q && out_stall_i) || out_load;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q       <= base_d;
    rd_addr_q    <= rd_addr_d;
    rd_base_q    <= rd_base_d;
    tgt_q        <= tgt_d;
    bit_q        <= bit_d;
    res_grant_q  <= res_grant_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_grant_q  <= res_grant_q;
      out_status_q <= res_status_q;
    end
  end

  always_comb begin
    state_d      = state_q;
    wa_d         = wa_q;
    base_d       = base_q;
    scan_more_d  = scan_more_q;
    rd_pend_d    = 1'b0;
    rd_addr_d    = rd_addr_q;
    rd_base_d    = rd_base_q;
    tgt_d        = tgt_q;
    bit_d        = bit_q;
    res_grant_d  = res_grant_q;
    res_status_d = res_status_q;
    ram_we       = 1'b0;
    ram_waddr    = wa_q;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = wa_q;
    out_load     = 1'b0;

    unique case (state_q)
      // zero the map after reset
      S_CLEAR: begin
        ram_we = 1'b1;
        if (wa_q == LAST_WA) begin
          wa_d    = '0;
          state_d = S_IDLE;
        end else begin
          wa_d = wa_q + AW'(1);
        end
      end

      S_IDLE: begin
        if (in_accept) begin
          wa_d         = '0;
          base_d       = '0;
          res_grant_d  = '0;
          res_status_d = ST_OK;
          unique case (bpfa_op_e'(opcode_i))
            OP_INIT:  state_d = S_INIT;
            OP_ALLOC: begin
              scan_more_d = 1'b1;
              state_d     = S_SCAN;
            end
            OP_FREE: begin
              if (free_pg >= NUM_X) begin
                res_status_d = ST_BEYOND;
                state_d      = S_DONE;
              end else begin
                tgt_d   = free_pg[CMPW-1:0];
                state_d = S_SEEK;
              end
            end
            default:  state_d = S_DONE;
          endcase
        end
      end

      // rewrite every word with the reserved ranges
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = init_word;
        if (wa_q == LAST_WA) begin
          state_d = S_DONE;
        end else begin
          wa_d   = wa_q + AW'(1);
          base_d = base_q + WB_C;
        end
      end

      // stream reads, test each word in the cycle after its read
      S_SCAN: begin
        if (scan_more_q) begin
          ram_re    = 1'b1;
          rd_pend_d = 1'b1;
          rd_addr_d = wa_q;
          rd_base_d = base_q;
          if (wa_q == LAST_WA) begin
            scan_more_d = 1'b0;
          end else begin
            wa_d   = wa_q + AW'(1);
            base_d = base_q + WB_C;
          end
        end
        if (rd_pend_q) begin
          if (|free_bits) begin
            ram_we      = 1'b1;
            ram_waddr   = rd_addr_q;
            ram_wdata   = ram_rdata | ({{(WORD_BITS-1){1'b0}}, 1'b1} << free_idx);
            res_grant_d = GRANT_W'(grant_full);
            rd_pend_d   = 1'b0;
            scan_more_d = 1'b0;
            state_d     = S_DONE;
          end else if (rd_addr_q == LAST_WA) begin
            res_status_d = ST_NO_MEM;
            state_d      = S_DONE;
          end
        end
      end

      // step to the word holding the page, then read it
      S_SEEK: begin
        if (seek_off < WB_C) begin
          ram_re  = 1'b1;
          bit_d   = seek_off[BIT_W-1:0];
          state_d = S_FWRITE;
        end else begin
          wa_d   = wa_q + AW'(1);
          base_d = base_q + WB_C;
        end
      end

      S_FWRITE: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata & ~({{(WORD_BITS-1){1'b0}}, 1'b1} << bit_q);
        state_d   = S_DONE;
      end

      // hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o       = out_valid_q;
  assign granted_address_o = out_grant_q;
  assign status_o          = out_status_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `BPFA_ASSERT(a_accept_starts_work, clk_i, rst_ni, in_accept |=> (state_q != S_IDLE), "accepted beat did not start work")
  `BPFA_ASSERT(a_fail_no_grant, clk_i, rst_ni, (out_valid_o && (status_o != ST_OK)) |-> (granted_address_o == '0), "failed beat carries a grant")
  `BPFA_ASSERT(a_write_states, clk_i, rst_ni, ram_we |-> (state_q == S_CLEAR || state_q == S_INIT || state_q == S_SCAN || state_q == S_FWRITE), "map write outside a writing state")
  `BPFA_ASSERT_NEVER(a_seek_overrun, clk_i, rst_ni, (state_q == S_SEEK) && (tgt_q < base_q), "free seek passed its page")
  `BPFA_ASSERT(a_scan_hit_ends, clk_i, rst_ni, (state_q == S_SCAN && rd_pend_q && (|free_bits)) |=> (state_q == S_DONE), "allocation hit did not finish")

endmodule

// File: rtl/bpfa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfa_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bpfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
